// ===== rtl/core/rxbq_pkg.sv =====
// Package for the receive-buffer ownership queue.
// Holds opcodes, error codes, ownership codes and size constants.
// No dependencies.
`timescale 1ns / 1ps
package rxbq_pkg;
  localparam int BUFFERS_DEF  = 256;
  localparam int MAX_POLL_DEF = 64;

  typedef enum logic [3:0] {
    OP_POST      = 4'd0,
    OP_REPOST    = 4'd1,
    OP_POST_FREE = 4'd2,
    OP_ACQUIRE   = 4'd3,
    OP_COMPLETE  = 4'd4,
    OP_POLL      = 4'd5,
    OP_QUERY     = 4'd6,
    OP_OVERRUN   = 4'd7,
    OP_STATS     = 4'd8
  } opcode_t;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_BADID = 3'd1;
  localparam logic [2:0] ERR_STATE = 3'd2;
  localparam logic [2:0] ERR_FULL  = 3'd3;
  localparam logic [2:0] ERR_EMPTY = 3'd4;

  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_POSTED = 2'd1;
  localparam logic [1:0] ST_FILLED = 2'd2;

  localparam logic [1:0] CFG_DMA_BASE = 2'd0;
  localparam logic [1:0] CFG_BUF_BYTES = 2'd1;
endpackage

// ===== rtl/core/rxbq_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rxbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/rxbq_addr_mul.sv =====
// Shift-and-add multiplier for the descriptor DMA address: base + id * stride.
// Depends on nothing; one stride bit per cycle.
`timescale 1ns / 1ps
module rxbq_addr_mul #(
  parameter int IW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [47:0]   base,
  input  logic [IW-1:0] id,
  input  logic [15:0]   stride,
  output logic          done,
  output logic [47:0]   addr
);
  logic [15:0] rem;
  logic [47:0] mcand;
  logic        run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        addr  <= base;
        mcand <= 48'(id);
        rem   <= stride;
      end else if (run) begin
        if (rem[0]) addr <= addr + mcand;
        mcand <= {mcand[46:0], 1'b0};
        rem   <= {1'b0, rem[15:1]};
        if (rem[15:1] == 15'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/rx_buffer_ownership_queue.sv =====
// Top level of the receive-buffer ownership queue.
// Depends on rxbq_pkg, rxbq_ram and rxbq_addr_mul.
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low. Busy then stays
// high until the cycle in which the last result of the transaction is
// strobed on valid; busy is already low in that cycle, so the next command
// can be taken at the same edge that accepts that result.
// Results cannot be held off: each is present for exactly one cycle.
// After reset a clearing pass walks every entry of the ownership table,
// during which busy is high. Commands that touch no table give their
// result from the read state; table commands go on to an execute state
// (one ownership-table read, one write-back). Acquire adds a bit-serial
// address multiply. The post-free command makes BUFFERS iterations
// through the ownership-table port (read, data wait, write-back). Poll
// passes an event-ring read state and an output state per returned event.
module rx_buffer_ownership_queue
  import rxbq_pkg::*;
#(
  parameter int BUFFERS  = BUFFERS_DEF,
  parameter int MAX_POLL = MAX_POLL_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  opcode,
  input  logic [7:0]  buf_index,
  input  logic [15:0] length,
  input  logic [6:0]  event_limit,
  input  logic [1:0]  stat_select,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        valid,
  output logic        ok,
  output logic [2:0]  error_code,
  output logic [7:0]  out_buf_index,
  output logic [47:0] out_dma_address,
  output logic [15:0] out_length,
  output logic [1:0]  buffer_state,
  output logic [8:0]  posted_count,
  output logic [31:0] stat_value,
  output logic        last
);
  localparam int AW = $clog2(BUFFERS);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_EX,
    S_ACQ_RD, S_ACQ_MUL, S_POLL_RD, S_POLL_OUT
  } state_t;

  state_t      state;
  logic [47:0] dma_base;
  logic [15:0] buffer_bytes;
  logic [3:0]  op;
  logic [7:0]  id;
  logic [15:0] len;
  logic [6:0]  poll_max;
  logic [6:0]  poll_n;
  logic [1:0]  sel;
  logic [AW-1:0] d_head, e_head;
  logic [CW-1:0] d_fill, e_fill;
  logic [AW-1:0] scan_i;
  logic [8:0]  scan_n;
  logic [31:0] stat_cnt [4];

  // Ownership table RAM.
  logic          own_we;
  logic [AW-1:0] own_waddr, own_raddr;
  logic [1:0]    own_wdata, own_rdata;
  // Descriptor ring RAM.
  logic          dr_we;
  logic [AW-1:0] dr_waddr, dr_raddr;
  logic [7:0]    dr_wdata, dr_rdata;
  // Event ring RAM.
  logic          er_we;
  logic [AW-1:0] er_waddr, er_raddr;
  logic [23:0]   er_wdata, er_rdata;

  logic        mul_go, mul_done;
  logic [47:0] mul_addr;

  rxbq_ram #(.WIDTH(2), .DEPTH(BUFFERS)) u_own (
    .clk, .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .raddr(own_raddr), .rdata(own_rdata));
  rxbq_ram #(.WIDTH(8), .DEPTH(BUFFERS)) u_desc (
    .clk, .we(dr_we), .waddr(dr_waddr), .wdata(dr_wdata),
    .raddr(dr_raddr), .rdata(dr_rdata));
  rxbq_ram #(.WIDTH(24), .DEPTH(BUFFERS)) u_evt (
    .clk, .we(er_we), .waddr(er_waddr), .wdata(er_wdata),
    .raddr(er_raddr), .rdata(er_rdata));
  rxbq_addr_mul #(.IW(8)) u_mul (
    .clk, .rst, .go(mul_go), .base(dma_base), .id(dr_rdata),
    .stride(buffer_bytes), .done(mul_done), .addr(mul_addr));

  // Ring slot helpers: head plus offset, wrapped once at BUFFERS.
  function automatic logic [AW-1:0] slot(logic [AW-1:0] h, logic [CW-1:0] o);
    logic [CW:0] s;
    s = {1'b0, {1'b0, h} + o};
    if (s >= (CW+1)'(BUFFERS)) s = s - (CW+1)'(BUFFERS);
    return s[AW-1:0];
  endfunction

  logic id_ok;
  assign id_ok = ({1'b0, id} < 9'(BUFFERS));
  logic d_full;
  assign d_full = (d_fill >= CW'(BUFFERS));

  assign busy = (state != S_IDLE);

  // Combinational RAM control; the registered block below mirrors the FSM.
  always_comb begin
    own_we = 1'b0; own_waddr = id[AW-1:0]; own_wdata = ST_POSTED;
    own_raddr = id[AW-1:0];
    dr_we = 1'b0; dr_waddr = slot(d_head, d_fill); dr_wdata = id;
    dr_raddr = d_head;
    er_we = 1'b0; er_waddr = slot(e_head, e_fill); er_wdata = {len, id};
    er_raddr = e_head;
    mul_go = 1'b0;
    case (state)
      S_CLEAR: begin
        own_we = 1'b1; own_waddr = scan_i; own_wdata = ST_FREE;
      end
      // The read address is held through the wait so the scanned entry
      // is still on the read port when the write-back decides.
      S_SCAN_RD, S_SCAN_WAIT: own_raddr = scan_i;
      S_SCAN_EX: begin
        own_waddr = scan_i;
        dr_wdata = 8'(scan_i);
        if (own_rdata == ST_FREE && !d_full) begin
          own_we = 1'b1; dr_we = 1'b1;
        end
      end
      S_EXEC: begin
        if (id_ok) begin
          if ((op == OP_POST && own_rdata == ST_FREE && !d_full) ||
              (op == OP_REPOST && own_rdata == ST_FILLED && !d_full)) begin
            own_we = 1'b1; dr_we = 1'b1;
          end
          if (op == OP_COMPLETE && own_rdata == ST_POSTED &&
              e_fill < CW'(BUFFERS)) begin
            own_we = 1'b1; own_wdata = ST_FILLED; er_we = 1'b1;
          end
        end
      end
      S_ACQ_RD: mul_go = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      dma_base <= '0; buffer_bytes <= 16'd2048;
      d_head <= '0; d_fill <= '0; e_head <= '0; e_fill <= '0;
      scan_i <= '0;
      for (int k = 0; k < 4; k++) stat_cnt[k] <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_DMA_BASE) dma_base <= cfg_data;
        else if (cfg_index == CFG_BUF_BYTES) buffer_bytes <= cfg_data[15:0];
      end
      case (state)
        S_CLEAR: begin
          scan_i <= scan_i + 1'b1;
          if (scan_i == AW'(BUFFERS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op <= opcode; id <= buf_index; len <= length; sel <= stat_select;
            poll_max <= (event_limit > 7'(MAX_POLL)) ? 7'(MAX_POLL) : event_limit;
            poll_n <= '0; scan_i <= '0; scan_n <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          ok <= 1'b0; error_code <= ERR_NONE; out_buf_index <= '0;
          out_dma_address <= '0; out_length <= '0; buffer_state <= '0;
          posted_count <= '0; stat_value <= '0; last <= 1'b1;
          case (op)
            OP_POST_FREE: state <= S_SCAN_RD;
            OP_ACQUIRE: begin
              if (d_fill == '0) begin
                error_code <= ERR_EMPTY; valid <= 1'b1; state <= S_IDLE;
              end else state <= S_ACQ_RD;
            end
            OP_POLL: begin
              if (poll_max == '0 || e_fill == '0) state <= S_IDLE;
              else state <= S_POLL_RD;
            end
            OP_OVERRUN: begin
              stat_cnt[2] <= stat_cnt[2] + 1'b1;
              stat_cnt[3] <= stat_cnt[3] + 1'b1;
              ok <= 1'b1; valid <= 1'b1; state <= S_IDLE;
            end
            OP_STATS: begin
              stat_value <= stat_cnt[sel]; ok <= 1'b1;
              valid <= 1'b1; state <= S_IDLE;
            end
            OP_POST, OP_REPOST, OP_COMPLETE, OP_QUERY: state <= S_EXEC;
            default: begin
              valid <= 1'b1; state <= S_IDLE;
            end
          endcase
        end
        S_EXEC: begin
          valid <= 1'b1; state <= S_IDLE;
          if (!id_ok) error_code <= ERR_BADID;
          else begin
            case (op)
              OP_POST, OP_REPOST: begin
                if (own_rdata != ((op == OP_POST) ? ST_FREE : ST_FILLED))
                  error_code <= ERR_STATE;
                else if (d_full) error_code <= ERR_FULL;
                else begin
                  ok <= 1'b1; d_fill <= d_fill + 1'b1;
                  stat_cnt[0] <= stat_cnt[0] + 1'b1;
                end
              end
              OP_COMPLETE: begin
                if (own_rdata != ST_POSTED) error_code <= ERR_STATE;
                else if (e_fill >= CW'(BUFFERS)) error_code <= ERR_FULL;
                else begin
                  ok <= 1'b1; e_fill <= e_fill + 1'b1;
                  stat_cnt[1] <= stat_cnt[1] + 1'b1;
                end
              end
              default: begin
                ok <= 1'b1; buffer_state <= own_rdata;
              end
            endcase
          end
        end
        S_SCAN_RD: state <= S_SCAN_WAIT;
        S_SCAN_WAIT: state <= S_SCAN_EX;
        S_SCAN_EX: begin
          if (own_rdata == ST_FREE && !d_full) begin
            d_fill <= d_fill + 1'b1; scan_n <= scan_n + 1'b1;
            stat_cnt[0] <= stat_cnt[0] + 1'b1;
          end
          if (scan_i == AW'(BUFFERS - 1)) begin
            ok <= 1'b1;
            posted_count <= (own_rdata == ST_FREE && !d_full) ?
                            scan_n + 1'b1 : scan_n;
            valid <= 1'b1; state <= S_IDLE;
          end else begin
            scan_i <= scan_i + 1'b1; state <= S_SCAN_RD;
          end
        end
        S_ACQ_RD: state <= S_ACQ_MUL;
        S_ACQ_MUL: begin
          if (mul_done) begin
            ok <= 1'b1; out_buf_index <= dr_rdata; out_dma_address <= mul_addr;
            d_head <= slot(d_head, CW'(1)); d_fill <= d_fill - 1'b1;
            valid <= 1'b1; state <= S_IDLE;
          end
        end
        S_POLL_RD: state <= S_POLL_OUT;
        S_POLL_OUT: begin
          ok <= 1'b1; out_buf_index <= er_rdata[7:0];
          out_length <= er_rdata[23:8];
          e_head <= slot(e_head, CW'(1)); e_fill <= e_fill - 1'b1;
          poll_n <= poll_n + 1'b1; valid <= 1'b1;
          if (poll_n + 1'b1 == poll_max || e_fill == CW'(1)) begin
            last <= 1'b1; state <= S_IDLE;
          end else begin
            last <= 1'b0; state <= S_POLL_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/rxbq_checker.sv =====
// Port-level checker for the receive-buffer ownership queue, with its bind.
// Depends on rx_buffer_ownership_queue.
`timescale 1ns / 1ps
module rxbq_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       valid,
  input logic       ok,
  input logic [2:0] error_code
);
  // A command is taken only while idle, so the next cycle is busy.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not set after start");
  // Results only appear during a transaction.
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy)) else $error("result outside a transaction");
  // A successful result never carries an error code.
  a_ok_noerr: assert property (@(posedge clk) disable iff (rst)
    (valid && ok) |-> error_code == 3'd0) else $error("ok with error");
  // No result during reset.
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !valid) else $error("result after reset");
endmodule

bind rx_buffer_ownership_queue rxbq_checker u_rxbq_checker (
  .clk, .rst, .start, .busy, .valid, .ok, .error_code);
